/* sv/buddy_block_allocator_top_defines.svh */
// Assertion macros used by the buddy block allocator checker.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bba_pkg.sv */
// Shared constants, types and helper functions of the buddy block allocator.
package bba_pkg;

    localparam int POOL_SIZE = 2048;
    localparam int LEVELS    = $clog2(POOL_SIZE);
    localparam int NODE_W    = LEVELS + 1;
    localparam int NODE_CNT  = 1 << NODE_W;
    localparam int AMT_W     = LEVELS + 1;
    localparam int OFF_W     = LEVELS;
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int ST_W      = 3;

    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_SHORT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOFIT   = 3'd2;
    localparam logic [ST_W-1:0] ST_ZERO    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOMATCH = 3'd4;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef struct packed {
        logic             split;
        logic             used;
        logic [AMT_W-1:0] request;
    } node_t;

    typedef struct packed {
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        node_t             wr_data;
        logic [NODE_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OFF_W-1:0] block_offset;
        logic [AMT_W-1:0] block_size;
        logic [AMT_W-1:0] free_total;
    } result_t;

    // Tree level whose block size is the smallest power of two covering amt.
    function automatic logic [LVL_W-1:0] target_level(input logic [AMT_W-1:0] amt);
        logic [AMT_W-1:0] v;
        logic [LVL_W-1:0] len;
        v   = amt - AMT_W'(1);
        len = '0;
        for (int i = 0; i < AMT_W; i++)
        begin
            if (v[i])
            begin
                len = LVL_W'(i + 1);
            end
        end
        return LVL_W'(LEVELS) - len;
    endfunction

    function automatic logic [OFF_W-1:0] node_offset(input logic [NODE_W-1:0] node,
                                                     input logic [LVL_W-1:0]  lvl);
        logic [NODE_W-1:0] sh;
        sh = node << (LVL_W'(LEVELS) - lvl);
        return sh[OFF_W-1:0];
    endfunction

    function automatic logic [AMT_W-1:0] node_size(input logic [LVL_W-1:0] lvl);
        return AMT_W'(1) << (LVL_W'(LEVELS) - lvl);
    endfunction

endpackage

/* sv/buddy_block_allocator_top.sv */
// Top level of the buddy block allocator: walker, node store and output register.
//
//  Channel   Signals                          Direction  Contents
//  s_*       s_tvalid s_tready s_tdata s_tuser  in        one request (kind, amount)
//  m_*       m_tvalid m_tready m_tdata m_tuser  out       one result per request
//
// After reset the node store is swept clear, all 4096 nodes, one node per
// cycle, with s_tready low. A request is accepted, each tree node visited is
// read, then checked, and each backing-off step goes up or across to a sibling;
// a claim then writes the block and each ancestor, or a release frees the block
// and checks each buddy while buddies merge; then the result is passed on.
// A stalled result waits in the output register while the next request runs.
module buddy_block_allocator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] amount, [15:12] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [10:0] block_offset, [22:11] block_size,
                                   // [34:23] free_total, [39:35] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    bba_pkg::ram_req_t ram_req;
    bba_pkg::node_t    ram_rd;
    bba_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;

    logic              m_valid_reg;
    bba_pkg::result_t  m_res_reg;

    bba_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_amount (s_tdata[bba_pkg::AMT_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rd    (ram_rd)
    );

    bba_node_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    // The output register frees up as soon as its result is transferred.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {5'd0, m_res_reg.free_total, m_res_reg.block_size,
                       m_res_reg.block_offset};

endmodule

/* sv/bba_node_ram.sv */
// Node store: split mark, used mark and recorded request for every tree node.
module bba_node_ram
(
    input  logic             clk,
    input  bba_pkg::ram_req_t req,
    output bba_pkg::node_t   rd_data
);

    bba_pkg::node_t mem [bba_pkg::NODE_CNT];
    bba_pkg::node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/bba_walker.sv */
// Tree walker: clearing pass, allocate and release searches, claim and merge.
module bba_walker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_kind,
    input  logic [bba_pkg::AMT_W-1:0]    in_amount,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bba_pkg::result_t             res,
    output bba_pkg::ram_req_t            ram_req,
    input  bba_pkg::node_t               ram_rd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_CHK, S_BACK, S_CLAIM, S_MARK,
        S_FREE, S_SIB_RD, S_SIB_CHK, S_OUT
    } state_t;

    localparam logic [bba_pkg::NODE_W-1:0] ROOT = bba_pkg::NODE_W'(1);
    localparam logic [bba_pkg::NODE_W-1:0] LAST = {bba_pkg::NODE_W{1'b1}};

    state_t                        state_reg,  state_next;
    logic [bba_pkg::NODE_W-1:0]    node_reg,   node_next;
    logic [bba_pkg::LVL_W-1:0]     lvl_reg,    lvl_next;
    logic [bba_pkg::LVL_W-1:0]     tgt_reg,    tgt_next;
    logic                          kind_reg,   kind_next;
    logic [bba_pkg::AMT_W-1:0]     amt_reg,    amt_next;
    logic [bba_pkg::AMT_W-1:0]     free_reg,   free_next;
    bba_pkg::result_t              res_reg,    res_next;

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        lvl_next   = lvl_reg;
        tgt_next   = tgt_reg;
        kind_next  = kind_reg;
        amt_next   = amt_reg;
        free_next  = free_reg;
        res_next   = res_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = node_reg;
        ram_req.wr_data = '0;
        ram_req.rd_addr = node_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_req.wr_en = 1'b1;
                node_next     = node_reg + bba_pkg::NODE_W'(1);
                if (node_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_kind;
                    amt_next  = in_amount;
                    node_next = ROOT;
                    lvl_next  = '0;
                    tgt_next  = bba_pkg::target_level(in_amount);
                    res_next  = '{status: bba_pkg::ST_DONE, block_offset: '0,
                                  block_size: '0, free_total: free_reg};
                    if (in_amount == '0)
                    begin
                        res_next.status = bba_pkg::ST_ZERO;
                        state_next      = S_OUT;
                    end
                    else if (in_kind == bba_pkg::KIND_ALLOC && in_amount > free_reg)
                    begin
                        res_next.status = bba_pkg::ST_SHORT;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_BACK;
                if (kind_reg == bba_pkg::KIND_ALLOC)
                begin
                    if (lvl_reg == tgt_reg)
                    begin
                        if (!ram_rd.split && !ram_rd.used)
                        begin
                            state_next = S_CLAIM;
                        end
                    end
                    else if (!ram_rd.used)
                    begin
                        if (!ram_rd.split)
                        begin
                            // A free whole subtree: its leftmost node at the
                            // target level is the one taken.
                            node_next  = node_reg << (tgt_reg - lvl_reg);
                            lvl_next   = tgt_reg;
                            state_next = S_CLAIM;
                        end
                        else
                        begin
                            node_next  = {node_reg[bba_pkg::NODE_W-2:0], 1'b0};
                            lvl_next   = lvl_reg + bba_pkg::LVL_W'(1);
                            state_next = S_RD;
                        end
                    end
                end
                else
                begin
                    if (ram_rd.used)
                    begin
                        if (ram_rd.request == amt_reg)
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else if (ram_rd.split && lvl_reg != bba_pkg::LVL_W'(bba_pkg::LEVELS))
                    begin
                        node_next  = {node_reg[bba_pkg::NODE_W-2:0], 1'b0};
                        lvl_next   = lvl_reg + bba_pkg::LVL_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_BACK:
            begin
                if (node_reg == ROOT)
                begin
                    res_next.status = (kind_reg == bba_pkg::KIND_ALLOC) ?
                                      bba_pkg::ST_NOFIT : bba_pkg::ST_NOMATCH;
                    state_next = S_OUT;
                end
                else if (node_reg[0])
                begin
                    node_next = node_reg >> 1;
                    lvl_next  = lvl_reg - bba_pkg::LVL_W'(1);
                end
                else
                begin
                    node_next  = node_reg + bba_pkg::NODE_W'(1);
                    state_next = S_RD;
                end
            end
            S_CLAIM:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = '{split: 1'b0, used: 1'b1, request: amt_reg};
                free_next       = free_reg - amt_reg;
                res_next        = '{status: bba_pkg::ST_DONE,
                                    block_offset: bba_pkg::node_offset(node_reg, lvl_reg),
                                    block_size: bba_pkg::node_size(lvl_reg),
                                    free_total: free_reg - amt_reg};
                node_next = node_reg >> 1;
                state_next = (node_reg == ROOT) ? S_OUT : S_MARK;
            end
            S_MARK:
            begin
                // Every ancestor of a claimed block is split.
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = '{split: 1'b1, used: 1'b0, request: '0};
                node_next       = node_reg >> 1;
                if (node_reg == ROOT)
                begin
                    state_next = S_OUT;
                end
            end
            S_FREE:
            begin
                ram_req.wr_en = 1'b1;
                free_next     = free_reg + amt_reg;
                res_next      = '{status: bba_pkg::ST_DONE,
                                  block_offset: bba_pkg::node_offset(node_reg, lvl_reg),
                                  block_size: bba_pkg::node_size(lvl_reg),
                                  free_total: free_reg + amt_reg};
                state_next = (node_reg == ROOT) ? S_OUT : S_SIB_RD;
            end
            S_SIB_RD:
            begin
                ram_req.rd_addr = {node_reg[bba_pkg::NODE_W-1:1], ~node_reg[0]};
                state_next      = S_SIB_CHK;
            end
            S_SIB_CHK:
            begin
                state_next = S_OUT;
                if (!ram_rd.split && !ram_rd.used)
                begin
                    // Both buddies free: the parent becomes one free block.
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = node_reg >> 1;
                    node_next       = node_reg >> 1;
                    if ((node_reg >> 1) != ROOT)
                    begin
                        state_next = S_SIB_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            node_reg  <= '0;
            lvl_reg   <= '0;
            tgt_reg   <= '0;
            kind_reg  <= 1'b0;
            amt_reg   <= '0;
            free_reg  <= bba_pkg::AMT_W'(bba_pkg::POOL_SIZE);
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            lvl_reg   <= lvl_next;
            tgt_reg   <= tgt_next;
            kind_reg  <= kind_next;
            amt_reg   <= amt_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

endmodule

/* sv/bba_checker.sv */
// Port-level checker for the buddy block allocator, bound to the top level.
`include "buddy_block_allocator_top_defines.svh"

module bba_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    `BBA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `BBA_ASSERT_NOW(a_fail_zero, m_tvalid && m_tuser != bba_pkg::ST_DONE, m_tdata[22:0] == 23'd0, "failed result carries a block")
    `BBA_ASSERT_NOW(a_pow2, m_tvalid && m_tuser == bba_pkg::ST_DONE, $onehot(m_tdata[22:11]), "block size not a power of two")
    `BBA_ASSERT_NOW(a_free_max, m_tvalid, m_tdata[34:23] <= 12'(bba_pkg::POOL_SIZE), "free total above pool size")

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);
